// ===== sv/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared constants and types of the popcount bucket sorter: sizes, the sort
// key and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 16;

    localparam int DATA_W   = 16;
    localparam int BUCKET_W = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int USED_BITS = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
    localparam logic [DATA_W-1:0] VALUE_MASK = DATA_W'((33'd1 << USED_BITS) - 33'd1);

    localparam int OUT_TDATA_W = ((DATA_W + BUCKET_W + 7) / 8) * 8;

    typedef struct packed {
        logic [BUCKET_W-1:0] pop;
        logic [DATA_W-1:0]   value;
    } key_t;

    typedef struct packed {
        logic load;
        logic insert;
        logic shift;
    } pbs_cmd_t;

    typedef struct packed {
        logic in_last;
        logic last_one;
    } pbs_status_t;

endpackage

// ===== sv/pbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbs_ctrl
// Sequencer: takes an input beat, lets the datapath insert it, and after the
// last beat of a set runs the emission until the sorted row is empty.
// ----------------------------------------------------------------------------
module pbs_ctrl
    import pbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  pbs_status_t status,
    output pbs_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd.load   = s_tvalid && s_tready_reg;
        cmd.insert = (state_reg == ST_INSERT);
        cmd.shift  = m_tvalid_reg && m_tready;
    end

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready_next = 1'b1;
                if (cmd.load) begin
                    state_next    = ST_INSERT;
                    s_tready_next = 1'b0;
                end
            end
            ST_INSERT: begin
                if (status.in_last) begin
                    state_next    = ST_EMIT;
                    m_tvalid_next = 1'b1;
                end else begin
                    state_next    = ST_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            ST_EMIT: begin
                if (cmd.shift && status.last_one) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b0;
                    s_tready_next = 1'b1;
                end
            end
            default: begin
                state_next    = ST_IDLE;
                s_tready_next = 1'b0;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== sv/pbs_datapath.sv =====
// ----------------------------------------------------------------------------
// pbs_datapath
// Input register with popcount, a sorted row of key cells filled by
// insertion, and the head of that row shifted out as the result.
// ----------------------------------------------------------------------------
module pbs_datapath
    import pbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pbs_cmd_t             cmd,
    output pbs_status_t          status,
    input  logic [DATA_W-1:0]    in_value,
    input  logic                 in_last,
    output logic [DATA_W-1:0]    out_value,
    output logic [BUCKET_W-1:0]  out_bucket,
    output logic                 out_bucket_end,
    output logic                 out_set_end,
    output logic                 out_overflowed
);

    logic [DATA_W-1:0]   in_val_reg;
    logic [BUCKET_W-1:0] in_pop_reg;
    logic                in_last_reg;

    key_t cell_reg  [CAPACITY];
    key_t cell_next [CAPACITY];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CAPACITY-1:0] le_vec;
    logic             full;
    key_t             new_key;

    logic [DATA_W-1:0]   masked;
    logic [BUCKET_W-1:0] pop_cnt;
    logic [2:0]          nib_cnt [4];

    // popcount in two levels: nibble counts, then their sum
    always_comb begin
        masked = in_value & VALUE_MASK;
        for (int n = 0; n < 4; n++) begin
            nib_cnt[n] = 3'(masked[4*n]) + 3'(masked[4*n+1])
                       + 3'(masked[4*n+2]) + 3'(masked[4*n+3]);
        end
        pop_cnt = BUCKET_W'(nib_cnt[0]) + BUCKET_W'(nib_cnt[1])
                + BUCKET_W'(nib_cnt[2]) + BUCKET_W'(nib_cnt[3]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_val_reg  <= masked;
            in_pop_reg  <= pop_cnt;
            in_last_reg <= in_last;
        end
    end

    assign new_key.pop   = in_pop_reg;
    assign new_key.value = in_val_reg;
    assign full = (count_reg == CNT_W'(CAPACITY));

    // occupied cells whose key does not exceed the new one form a prefix
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            le_vec[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] <= new_key);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_next[i] = cell_reg[i];
        end
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.insert) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
                if (!le_vec[0]) begin
                    cell_next[0] = new_key;
                end
                for (int i = 1; i < CAPACITY; i++) begin
                    if (!le_vec[i]) begin
                        cell_next[i] = le_vec[i-1] ? new_key : cell_reg[i-1];
                    end
                end
            end
        end else if (cmd.shift) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                cell_next[i] = cell_reg[i+1];
            end
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1)) begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign status.in_last  = in_last_reg;
    assign status.last_one = (count_reg == CNT_W'(1));

    assign out_value      = cell_reg[0].value;
    assign out_bucket     = cell_reg[0].pop;
    assign out_set_end    = status.last_one;
    assign out_bucket_end = status.last_one || (cell_reg[1].pop != cell_reg[0].pop);
    assign out_overflowed = ovf_reg;

endmodule

// ===== sv/popcount_bucket_sorter_top.sv =====
// ----------------------------------------------------------------------------
// popcount_bucket_sorter_top
// Collects a set of unsigned values and emits them ordered by set-bit count,
// then by value.
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one value per beat in s_tdata; s_tlast closes a set
//   master stream returns the set sorted: value and bucket in m_tdata,
//   m_tlast on the last result of the set, m_tuser holds bucket_end and
//   the overflow flag
//   each input beat is first registered with its popcount, then inserted
//   into the sorted row of cells; no new beat is taken until it is inserted
//   the first result is valid once the last beat has been inserted,
//   then one result per cycle while m_tready is high
//   no input is taken during emission; the next set starts after the last
//   result has been taken
//   up to 64 values are held; further beats of a set are dropped and the
//   overflow flag is raised on every result of that set
//   a stalled master holds the head of the row and its flags unchanged
//   reset empties the store and clears the overflow flag; s_tready rises
//   in the cycle after reset is released
// ----------------------------------------------------------------------------
module popcount_bucket_sorter_top
    import pbs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DATA_W-1:0]      s_tdata,   // [15:0] value
    input  logic                   s_tlast,   // last_item
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [15:0] sorted_value, [20:16] bucket
    output logic [1:0]             m_tuser,   // [0] bucket_end, [1] overflowed
    output logic                   m_tlast    // set_end
);

    pbs_cmd_t            cmd;
    pbs_status_t         status;
    logic [DATA_W-1:0]   out_value;
    logic [BUCKET_W-1:0] out_bucket;
    logic                out_bucket_end;
    logic                out_set_end;
    logic                out_overflowed;

    pbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbs_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_value       (s_tdata),
        .in_last        (s_tlast),
        .out_value      (out_value),
        .out_bucket     (out_bucket),
        .out_bucket_end (out_bucket_end),
        .out_set_end    (out_set_end),
        .out_overflowed (out_overflowed)
    );

    assign m_tdata = {(OUT_TDATA_W - DATA_W - BUCKET_W)'(0), out_bucket, out_value};
    assign m_tuser = {out_overflowed, out_bucket_end};
    assign m_tlast = out_set_end;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the popcount bucket sorter. Sets of values are
// streamed in, mostly with random gaps, and a predictor sorts each closed
// set by set-bit count, then by value. Every result beat is checked against
// the oldest predicted beat, with exact-capacity and overflowing sets included.
// ----------------------------------------------------------------------------
module tb;
    import pbs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [BUCKET_W-1:0] bucket;
        logic                bucket_end;
        logic                set_end;
        logic                overflowed;
    } sorted_result_t;

    class popcount_sort_board;
        logic [DATA_W-1:0] held [CAPACITY];
        int                held_count;
        bit                dropped;
        sorted_result_t    awaited [$];
        int                errors;
        int                values_taken;
        int                sets_closed;
        int                overflow_sets;
        int                results_seen;

        function new();
            held_count    = 0;
            dropped       = 1'b0;
            errors        = 0;
            values_taken  = 0;
            sets_closed   = 0;
            overflow_sets = 0;
            results_seen  = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [BUCKET_W+DATA_W-1:0] order_of(logic [DATA_W-1:0] v);
            return {BUCKET_W'($countones(v)), v};
        endfunction

        // one accepted input beat; a closing beat releases the whole sorted set
        function void note_value(logic [DATA_W-1:0] v, logic closes);
            logic [DATA_W-1:0] row [CAPACITY];
            logic [DATA_W-1:0] cur;
            sorted_result_t    r;
            int                j;
            v = v & VALUE_MASK;
            values_taken++;
            if (held_count < CAPACITY) begin
                held[held_count] = v;
                held_count++;
            end else begin
                dropped = 1'b1;
            end
            if (!closes)
                return;
            for (int i = 0; i < held_count; i++) begin
                cur = held[i];
                j = i;
                while (j > 0 && order_of(row[j-1]) > order_of(cur)) begin
                    row[j] = row[j-1];
                    j--;
                end
                row[j] = cur;
            end
            for (int i = 0; i < held_count; i++) begin
                r.value      = row[i];
                r.bucket     = BUCKET_W'($countones(row[i]));
                r.set_end    = (i + 1 == held_count);
                r.bucket_end = r.set_end ? 1'b1
                             : ($countones(row[i+1]) != $countones(row[i]));
                r.overflowed = dropped;
                awaited.insert(awaited.size(), r);
            end
            sets_closed++;
            if (dropped)
                overflow_sets++;
            held_count = 0;
            dropped    = 1'b0;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic [1:0] user,
                                   logic tlast);
            sorted_result_t want, got;
            got.value      = data[DATA_W-1:0];
            got.bucket     = data[DATA_W+BUCKET_W-1:DATA_W];
            got.bucket_end = user[0];
            got.set_end    = tlast;
            got.overflowed = user[1];
            results_seen++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: value=%h bucket=%0d",
                         $time, got.value, got.bucket);
                return;
            end
            want = awaited.pop_front();
            if (got.value !== want.value) begin
                errors++;
                $display("%0t: sorted_value expected %h got %h", $time, want.value, got.value);
            end
            if (got.bucket !== want.bucket) begin
                errors++;
                $display("%0t: bucket expected %0d got %0d", $time, want.bucket, got.bucket);
            end
            if (got.bucket_end !== want.bucket_end) begin
                errors++;
                $display("%0t: bucket_end expected %b got %b (value %h)", $time,
                         want.bucket_end, got.bucket_end, want.value);
            end
            if (got.set_end !== want.set_end) begin
                errors++;
                $display("%0t: set_end expected %b got %b (value %h)", $time,
                         want.set_end, got.set_end, want.value);
            end
            if (got.overflowed !== want.overflowed) begin
                errors++;
                $display("%0t: overflowed expected %b got %b (value %h)", $time,
                         want.overflowed, got.overflowed, want.value);
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    popcount_sort_board sb;
    logic [DATA_W-1:0]  set_buf [$];
    logic [DATA_W-1:0]  prev_pick;
    bit                 steady_send;
    bit                 hold_done;
    int                 hold_left;
    int                 steady_left;
    int                 cycle_count;
    int                 random_values;

    popcount_bucket_sorter_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // receiver: random stalls, one long hold-off once a big set is waiting,
    // then a stretch of steady acceptance
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
            if (hold_left == 1)
                steady_left <= 150;
        end else if (!hold_done && sb.pending() >= 10) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else if (steady_left > 0) begin
            m_tready    <= 1'b1;
            steady_left <= steady_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 22);
        end
    end

    function logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = prev_pick;
            1:       v = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            2:       v = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
            3:       v = $urandom_range(0, 1) ? '1 : '0;
            default: v = DATA_W'($urandom_range(0, 65535));
        endcase
        prev_pick = v;
        return v;
    endfunction

    // entered and left at a falling edge
    task send_value(input logic [DATA_W-1:0] v, input logic closes);
        if (!steady_send) begin
            while ($urandom_range(0, 99) < 22) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closes;
        do @(posedge aclk); while (!s_tready);
        sb.note_value(v, closes);
        @(negedge aclk);
    endtask

    task send_buffered();
        for (int i = 0; i < set_buf.size(); i++)
            send_value(set_buf[i], i == set_buf.size() - 1);
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task fill_random(input int count);
        set_buf.delete();
        for (int i = 0; i < count; i++)
            set_buf.insert(set_buf.size(), pick_value());
        random_values += count;
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        prev_pick     = '0;
        steady_send   = 1'b0;
        hold_done     = 1'b0;
        hold_left     = 0;
        steady_left   = 0;
        cycle_count   = 0;
        random_values = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: single-value sets at both extremes
        set_buf = '{16'h0000};
        send_buffered();
        set_buf = '{16'hFFFF};
        send_buffered();
        // extremes at both ends of the bucket range
        set_buf = '{16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFE, 16'h0100};
        send_buffered();
        // equal values, several in one bucket
        set_buf = '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555};
        send_buffered();
        set_buf = '{16'h0003, 16'h0005, 16'h0003, 16'h0006, 16'h0009};
        send_buffered();
        wait_drained();

        // store filled exactly, no idle gaps on the input side
        steady_send = 1'b1;
        fill_random(CAPACITY);
        send_buffered();
        steady_send = 1'b0;

        // overflow: the closing beat itself lands on a full store
        fill_random(CAPACITY + $urandom_range(1, 3));
        send_buffered();

        while (random_values < 132) begin
            fill_random($urandom_range(1, 8));
            send_buffered();
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d values in %0d sets (%0d with dropped values), %0d results",
                 sb.values_taken, sb.sets_closed, sb.overflow_sets, sb.results_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
